/* src/lru_linked_list_tracker_defines.svh */
`ifndef LRU_LINKED_LIST_TRACKER_DEFINES_SVH
`define LRU_LINKED_LIST_TRACKER_DEFINES_SVH

// clocked check, off while reset is asserted
`define LRU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lru tracker check failed");

// clocked check that also holds during reset
`define LRU_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lru tracker check failed");

`endif

/* src/lru_pkg.sv */
`default_nettype none

package lru_pkg;

	localparam int IDX_W           = 8;
	localparam int SLOT_LIMIT      = 256;
	localparam int ENTRY_COUNT_DEF = 255;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_MOVE   = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_LISTED = 2'd1,
		STAT_ABSENT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_DECODE = 2'd1,
		S_LINK   = 2'd2
	} fsm_state_t;

	typedef struct packed {
		logic    load;
		logic    link;
		logic    unlink;
		logic    finish;
		status_t code;
	} ctl_cmd_t;

	typedef struct packed {
		logic valid;
		logic listed;
	} dp_stat_t;

	function automatic int slot_depth(input int ec);
		return (ec >= SLOT_LIMIT) ? SLOT_LIMIT : ec + 1;
	endfunction

	function automatic int addr_width(input int depth);
		return $clog2(depth);
	endfunction

endpackage

`default_nettype wire

/* src/lru_linked_list_tracker.sv */
// lru_linked_list_tracker: eviction-order tracker kept as a doubly linked list
// of numbered entries, head is the oldest entry and tail the newest.
// request channel: req_type and entry_index are taken at a rising edge with
// start high and busy low. req_type selects append at tail, remove, move to
// tail or query only.
// result channel: done is high for exactly one cycle per request; during that
// cycle head_index, tail_index (0 when the list is empty) and status hold the
// answer. the receiver cannot stall, so every result must be taken then.
// the result cycle follows the DECODE state for append, remove, query and
// error cases, and the LINK state after DECODE for a successful move. a new
// request may be accepted in the result cycle; busy is high in DECODE and
// LINK. the entry's links are read from the link memories at the accepting
// edge; unlinking and relinking each use the single write port of those
// memories, unlinking in DECODE, relinking in DECODE (append) or LINK (move).
// reset: asynchronous, empties the list (head and tail 0, all membership bits
// cleared) at once; no clearing pass is needed and requests are taken right
// after reset is released.
`default_nettype none
`include "lru_linked_list_tracker_defines.svh"

module lru_linked_list_tracker import lru_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       req_type,
	input  wire logic [IDX_W-1:0] entry_index,
	output logic                  done,
	output logic      [IDX_W-1:0] head_index,
	output logic      [IDX_W-1:0] tail_index,
	output logic      [1:0]       status
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	lru_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.stat    (stat),
		.busy    (busy),
		.cmd     (cmd)
	);

	lru_dpath #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_index(entry_index),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.head_index (head_index),
		.tail_index (tail_index),
		.status     (status)
	);

	`LRU_ASSERT(a_accept_busy, (start && !busy) |=> busy)
	`LRU_ASSERT(a_done_idle, done |-> !busy)
	`LRU_ASSERT(a_done_spaced, done |=> !done)
	`LRU_ASSERT(a_empty_both, (head_index == '0) == (tail_index == '0))

endmodule

`default_nettype wire

/* src/lru_ram.sv */
`default_nettype none

module lru_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* src/lru_ctrl.sv */
`default_nettype none

module lru_ctrl import lru_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_type,
	input  wire dp_stat_t   stat,
	output logic            busy,
	output ctl_cmd_t        cmd
);

	fsm_state_t state_q, state_d;
	req_t       req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_t'(req_type);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (req_q == REQ_MOVE && stat.valid && stat.listed) begin
					state_d = S_LINK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LINK: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy       = 1'b1;
		cmd.load   = 1'b0;
		cmd.link   = 1'b0;
		cmd.unlink = 1'b0;
		cmd.finish = 1'b0;
		cmd.code   = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_DECODE: begin
				if (req_q == REQ_QUERY) begin
					cmd.finish = 1'b1;
				end else if (!stat.valid) begin
					cmd.finish = 1'b1;
					cmd.code   = STAT_ABSENT;
				end else begin
					case (req_q) inside
						REQ_APPEND: begin
							cmd.finish = 1'b1;
							if (stat.listed) begin
								cmd.code = STAT_LISTED;
							end else begin
								cmd.link = 1'b1;
							end
						end
						REQ_REMOVE, REQ_MOVE: begin
							if (!stat.listed) begin
								cmd.finish = 1'b1;
								cmd.code   = STAT_ABSENT;
							end else begin
								cmd.unlink = 1'b1;
								cmd.finish = (req_q == REQ_REMOVE);
							end
						end
						default: cmd.finish = 1'b1;
					endcase
				end
			end
			S_LINK: begin
				cmd.link   = 1'b1;
				cmd.finish = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

/* src/lru_dpath.sv */
`default_nettype none

module lru_dpath import lru_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] entry_index,
	input  wire ctl_cmd_t         cmd,
	output dp_stat_t              stat,
	output logic                  done,
	output logic      [IDX_W-1:0] head_index,
	output logic      [IDX_W-1:0] tail_index,
	output logic      [1:0]       status
);

	localparam int DEPTH  = slot_depth(ENTRY_COUNT);
	localparam int ADDR_W = addr_width(DEPTH);

	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] idx_s;
	logic [ADDR_W-1:0] head_q, tail_q;
	logic [DEPTH-1:0]  member_q;
	status_t           status_q;
	logic              done_q;

	logic [ADDR_W-1:0] prev_rd, next_rd;
	logic [ADDR_W-1:0] p_lnk, n_lnk;
	logic              prev_we, next_we;
	logic [ADDR_W-1:0] prev_wa, prev_wd, next_wa, next_wd;
	logic              idx_ok;

	assign idx_s  = idx_q[ADDR_W-1:0];
	assign idx_ok = (idx_q != '0) && (int'(idx_q) <= ENTRY_COUNT);

	assign stat.valid  = idx_ok;
	assign stat.listed = idx_ok && member_q[idx_s];

	// head has no predecessor and tail no successor, whatever the links hold
	assign p_lnk = (idx_s == head_q) ? '0 : prev_rd;
	assign n_lnk = (idx_s == tail_q) ? '0 : next_rd;

	always_comb begin
		prev_we = 1'b0;
		prev_wa = idx_s;
		prev_wd = tail_q;
		next_we = 1'b0;
		next_wa = tail_q;
		next_wd = idx_s;
		if (cmd.link) begin
			prev_we = 1'b1;
			next_we = (tail_q != '0);
		end else if (cmd.unlink) begin
			next_we = (p_lnk != '0);
			next_wa = p_lnk;
			next_wd = n_lnk;
			prev_we = (n_lnk != '0);
			prev_wa = n_lnk;
			prev_wd = p_lnk;
		end
	end

	lru_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_prev_ram (
		.clk    (clk),
		.wr_en  (prev_we),
		.wr_addr(prev_wa),
		.wr_data(prev_wd),
		.rd_addr(entry_index[ADDR_W-1:0]),
		.rd_data(prev_rd)
	);

	lru_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_next_ram (
		.clk    (clk),
		.wr_en  (next_we),
		.wr_addr(next_wa),
		.wr_data(next_wd),
		.rd_addr(entry_index[ADDR_W-1:0]),
		.rd_data(next_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			member_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.link) begin
				if (tail_q == '0) begin
					head_q <= idx_s;
				end
				tail_q          <= idx_s;
				member_q[idx_s] <= 1'b1;
			end else if (cmd.unlink) begin
				if (p_lnk == '0) begin
					head_q <= n_lnk;
				end
				if (n_lnk == '0) begin
					tail_q <= p_lnk;
				end
				member_q[idx_s] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= entry_index;
		end
		if (cmd.finish) begin
			status_q <= cmd.code;
		end
	end

	assign done       = done_q;
	assign head_index = IDX_W'(head_q);
	assign tail_index = IDX_W'(tail_q);
	assign status     = status_q;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import lru_pkg::*;

	localparam int ENTRY_COUNT = ENTRY_COUNT_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [IDX_W-1:0] head;
		logic [IDX_W-1:0] tail;
		status_t          code;
	} order_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req_type;
	logic [IDX_W-1:0] entry_index;
	logic             done;
	logic [IDX_W-1:0] head_index;
	logic [IDX_W-1:0] tail_index;
	logic [1:0]       status;

	// own copy of the list
	logic [IDX_W-1:0] lru_prev [SLOT_LIMIT];
	logic [IDX_W-1:0] lru_next [SLOT_LIMIT];
	logic             lru_listed [SLOT_LIMIT];
	logic [IDX_W-1:0] lru_head;
	logic [IDX_W-1:0] lru_tail;
	int               list_len;
	int               peak_len;

	order_t answer_q[$];
	int     error_count;
	int     cycle_count;
	int     burst_left;
	int     req_count [4];
	int     status_count [3];

	lru_linked_list_tracker #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.entry_index(entry_index),
		.done       (done),
		.head_index (head_index),
		.tail_index (tail_index),
		.status     (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d answers outstanding", $time, answer_q.size());
			$display("testbench failed");
			$finish;
		end
	end

	task automatic check_field(input string name, input logic [IDX_W-1:0] exp_v,
			input logic [IDX_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		order_t ans;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				$display("%0t: result beat with none expected, head %0d tail %0d status %0d",
					$time, head_index, tail_index, status);
				error_count++;
			end else begin
				ans = answer_q.pop_front();
				check_field("head_index", ans.head, head_index);
				check_field("tail_index", ans.tail, tail_index);
				check_field("status", IDX_W'(ans.code), IDX_W'(status));
			end
		end
	end

	task automatic link_tail(input logic [IDX_W-1:0] idx);
		lru_prev[idx] = lru_tail;
		lru_next[idx] = '0;
		if (lru_tail == 0)
			lru_head = idx;
		else
			lru_next[lru_tail] = idx;
		lru_tail = idx;
		lru_listed[idx] = 1'b1;
		list_len++;
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	task automatic predict_order(input req_t r, input logic [IDX_W-1:0] idx);
		order_t           ans;
		logic [IDX_W-1:0] p;
		logic [IDX_W-1:0] n;
		ans.code = STAT_OK;
		if (r != REQ_QUERY) begin
			if (idx == 0 || idx > ENTRY_COUNT) begin
				ans.code = STAT_ABSENT;
			end else if (r == REQ_APPEND) begin
				if (lru_listed[idx])
					ans.code = STAT_LISTED;
				else
					link_tail(idx);
			end else if (!lru_listed[idx]) begin
				ans.code = STAT_ABSENT;
			end else begin
				p = lru_prev[idx];
				n = lru_next[idx];
				if (p == 0)
					lru_head = n;
				else
					lru_next[p] = n;
				if (n == 0)
					lru_tail = p;
				else
					lru_prev[n] = p;
				lru_listed[idx] = 1'b0;
				list_len--;
				if (r == REQ_MOVE)
					link_tail(idx);
			end
		end
		ans.head = lru_head;
		ans.tail = lru_tail;
		req_count[r]++;
		status_count[ans.code]++;
		answer_q.push_back(ans);
	endtask

	// one request beat, with random gaps between bursts
	task automatic send_req(input req_t r, input logic [IDX_W-1:0] idx);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		req_type <= r;
		entry_index <= idx;
		do @(posedge clk); while (busy);
		predict_order(r, idx);
	endtask

	function automatic logic [IDX_W-1:0] pick_listed(input int hi);
		int r;
		int j;
		r = $urandom_range(1, hi);
		for (int k = 0; k < hi; k++) begin
			j = ((r - 1 + k) % hi) + 1;
			if (lru_listed[j])
				return IDX_W'(j);
		end
		return IDX_W'(r);
	endfunction

	task automatic send_random(input int hi);
		int               sel;
		int               roll;
		req_t             r;
		logic [IDX_W-1:0] idx;
		sel = $urandom_range(0, 99);
		roll = $urandom_range(0, 99);
		if (sel < 35)
			r = REQ_APPEND;
		else if (sel < 60)
			r = REQ_REMOVE;
		else if (sel < 88)
			r = REQ_MOVE;
		else
			r = REQ_QUERY;
		if (r == REQ_QUERY || roll < 5)
			idx = IDX_W'($urandom_range(0, 255));
		else if (roll < 10)
			idx = '0;
		else if (r != REQ_APPEND && roll < 85)
			idx = pick_listed(hi);
		else
			idx = IDX_W'($urandom_range(1, hi));
		send_req(r, idx);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		send_req(REQ_QUERY, 8'hAA);
		send_req(REQ_REMOVE, 8'd1);
		send_req(REQ_MOVE, 8'd255);
		send_req(REQ_APPEND, 8'd0);
		send_req(REQ_REMOVE, 8'd0);
		send_req(REQ_MOVE, 8'd0);
		send_req(REQ_APPEND, 8'd255);
		send_req(REQ_MOVE, 8'd255);
		send_req(REQ_APPEND, 8'd1);
		send_req(REQ_APPEND, 8'd255);
		send_req(REQ_APPEND, 8'd128);
		send_req(REQ_QUERY, 8'h55);
		send_req(REQ_MOVE, 8'd255);
		send_req(REQ_MOVE, 8'd255);
		send_req(REQ_MOVE, 8'd1);
		send_req(REQ_REMOVE, 8'd128);
		send_req(REQ_APPEND, 8'd128);
		send_req(REQ_REMOVE, 8'd1);
		send_req(REQ_REMOVE, 8'd128);
		send_req(REQ_REMOVE, 8'd128);
		send_req(REQ_REMOVE, 8'd255);
		send_req(REQ_QUERY, 8'h00);
	endtask

	task automatic test_fill_and_drain();
		logic [IDX_W-1:0] perm [ENTRY_COUNT];
		logic [IDX_W-1:0] tmp;
		int               j;
		for (int i = 0; i < ENTRY_COUNT; i++)
			perm[i] = IDX_W'(i + 1);
		for (int i = ENTRY_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < ENTRY_COUNT; i++)
			send_req(REQ_APPEND, perm[i]);
		// full list: moves plus a few refused appends
		for (int i = 0; i < 100; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_req(REQ_APPEND, IDX_W'($urandom_range(1, ENTRY_COUNT)));
			else
				send_req(REQ_MOVE, IDX_W'($urandom_range(1, ENTRY_COUNT)));
		end
		for (int i = ENTRY_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < ENTRY_COUNT; i++)
			send_req(REQ_REMOVE, perm[i]);
	endtask

	task automatic test_random_narrow();
		for (int i = 0; i < 700; i++) begin
			send_random(($urandom_range(0, 3) == 0) ? 4 : 16);
			if (i == 350)
				hold_until_drained();
		end
	endtask

	task automatic test_random_wide();
		for (int i = 0; i < 520; i++)
			send_random(ENTRY_COUNT);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_QUERY;
		entry_index = '0;
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		lru_head = '0;
		lru_tail = '0;
		list_len = 0;
		peak_len = 0;
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			lru_prev[i] = '0;
			lru_next[i] = '0;
			lru_listed[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++)
			req_count[i] = 0;
		for (int i = 0; i < 3; i++)
			status_count[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_narrow();
		test_random_wide();

		start <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (answer_q.size() != 0) begin
			$display("%0t: %0d answers never arrived", $time, answer_q.size());
			error_count++;
		end

		$display("requests: %0d append, %0d remove, %0d move, %0d query; longest list %0d",
			req_count[REQ_APPEND], req_count[REQ_REMOVE], req_count[REQ_MOVE],
			req_count[REQ_QUERY], peak_len);
		$display("answers: %0d ok, %0d already listed, %0d not listed; %0d mismatches",
			status_count[STAT_OK], status_count[STAT_LISTED], status_count[STAT_ABSENT],
			error_count);
		if (error_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
